// ===== hw/rtl/smf_pkg.sv =====
package smf_pkg;

  // Window geometry
  localparam int MAX_WINDOW = 15;
  localparam int ODD_CAP    = (MAX_WINDOW - 1) | 1;
  localparam int HALF_CAP   = MAX_WINDOW / 2;
  localparam int LEN_W      = $clog2(MAX_WINDOW + 1);
  localparam int CNT_W      = $clog2(HALF_CAP + 1);

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int WSIZE_W  = 4;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Request handed from the window stage to the median/output stage
  typedef struct packed {
    logic    valid;
    logic    last;
    logic    bypass;
    sample_t data;
  } stage_tag_t;

  // Half window (w/2) for a window_size setting: even raised to odd, capped
  function automatic logic [CNT_W-1:0] window_half(input logic [WSIZE_W-1:0] ws);
    logic [WSIZE_W:0] w_odd;
    w_odd = {1'b0, ws} | (WSIZE_W+1)'(1);
    if (int'(w_odd) > ODD_CAP) begin
      w_odd = (WSIZE_W+1)'(ODD_CAP);
    end
    return CNT_W'(w_odd >> 1);
  endfunction

endpackage

// ===== hw/rtl/smf_window.sv =====
module smf_window
  import smf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [WSIZE_W-1:0]   window_size,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sample_t              in_sample,
  input  logic                 in_last,
  input  logic                 adv,
  output stage_tag_t           tag,
  output sample_t              history [MAX_WINDOW],
  output logic [CNT_W-1:0]     half
);

  logic                 bypass;
  logic                 fresh;
  logic                 flushing;
  logic [CNT_W-1:0]     flush_left;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     base_count;
  logic [CNT_W-1:0]     count_next;
  logic                 in_fire;
  logic                 do_push;
  logic                 flush_push;
  logic                 flush_final;
  logic                 emit;
  sample_t              push_val;
  sample_t              base_hist [MAX_WINDOW];
  stage_tag_t           tag_next;

  // Decode the window setting
  assign bypass = (window_size <= WSIZE_W'(1));
  assign half   = window_half(window_size);

  // Handshake: inputs wait while the flush drains
  assign in_ready    = adv && !flushing;
  assign in_fire     = in_valid && in_ready;
  assign flush_push  = flushing && adv;
  assign flush_final = flush_push && (flush_left == CNT_W'(1));
  assign do_push     = flush_push || (in_fire && !bypass);
  assign push_val    = flushing ? '0 : in_sample;

  // A cleared column reads as all padding zeros
  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      base_hist[i] = fresh ? '0 : history[i];
    end
  end
  assign base_count = fresh ? '0 : count;
  assign emit       = (base_count >= half);
  assign count_next = (base_count == CNT_W'(HALF_CAP)) ? base_count
                                                       : base_count + CNT_W'(1);

  // Next request for the median stage
  always_comb begin
    tag_next = tag;
    if (flush_push) begin
      tag_next.valid  = emit;
      tag_next.last   = flush_final;
      tag_next.bypass = 1'b0;
      tag_next.data   = '0;
    end else if (in_fire) begin
      tag_next.valid  = bypass || emit;
      tag_next.last   = bypass && in_last;
      tag_next.bypass = bypass;
      tag_next.data   = in_sample;
    end else if (adv) begin
      tag_next.valid  = 1'b0;
    end
  end

  // History shift line, newest first
  always_ff @(posedge clk) begin
    if (do_push) begin
      history[0] <= push_val;
      for (int i = 1; i < MAX_WINDOW; i++) begin
        history[i] <= base_hist[i-1];
      end
    end
  end

  // Control state and request register; payload needs no reset
  always_ff @(posedge clk) begin
    tag.last   <= tag_next.last;
    tag.bypass <= tag_next.bypass;
    tag.data   <= tag_next.data;
    if (rst) begin
      tag.valid  <= 1'b0;
      fresh      <= 1'b1;
      flushing   <= 1'b0;
      flush_left <= '0;
      count      <= '0;
    end else begin
      tag.valid <= tag_next.valid;
      if (do_push) begin
        count <= count_next;
      end
      if (flush_final || (in_fire && bypass && in_last)) begin
        fresh <= 1'b1;
      end else if (do_push) begin
        fresh <= 1'b0;
      end
      if (in_fire && !bypass && in_last) begin
        flushing   <= 1'b1;
        flush_left <= half;
      end else if (flush_push) begin
        flush_left <= flush_left - CNT_W'(1);
        if (flush_final) begin
          flushing <= 1'b0;
        end
      end
    end
  end

  a_no_input_in_flush: assert property (@(posedge clk) disable iff (rst)
    flushing |-> !in_ready)
    else $error("input taken during flush");

  a_flush_count_live: assert property (@(posedge clk) disable iff (rst)
    flushing |-> (flush_left != '0))
    else $error("flush running with nothing left");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    flush_final |=> (fresh && !flushing && tag.valid && tag.last))
    else $error("final flush push did not close the column");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(count) && $stable(tag.valid)))
    else $error("window state moved while stalled");

endmodule

// ===== hw/rtl/smf_rank_select.sv =====
module smf_rank_select
  import smf_pkg::*;
(
  input  sample_t           history [MAX_WINDOW],
  input  logic [CNT_W-1:0]  half,
  output sample_t           median
);

  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] rank [MAX_WINDOW];
  logic             hit  [MAX_WINDOW];

  assign len = LEN_W'({half, 1'b1});

  // Rank of each live entry; ties broken by position so ranks are unique
  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      rank[i] = '0;
      for (int j = 0; j < MAX_WINDOW; j++) begin
        if ((j != i) && (LEN_W'(j) < len) &&
            ((history[j] < history[i]) || ((history[j] == history[i]) && (j < i)))) begin
          rank[i] = rank[i] + LEN_W'(1);
        end
      end
      hit[i] = (LEN_W'(i) < len) && (rank[i] == LEN_W'(half));
    end
  end

  // Exactly one live entry holds the middle rank
  always_comb begin
    median = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (hit[i]) begin
        median = history[i];
      end
    end
  end

endmodule

// ===== hw/rtl/sliding_median_filter_core.sv =====
// Running median filter over one column of signed Q2.14 samples with zero
// padding at both ends. Each accepted sample shifts into a 15-entry history;
// the median of the newest w entries (w = window_size raised to odd) is found
// by a combinational rank compare and registered on the output. One sample is
// taken per cycle unless a flush or output back-pressure holds it. The first
// w/2 samples of a column give no result; after the tlast sample a flush of
// w/2 zero pushes gives one result each with s_axis_tready low, so a column
// of n samples gives n results, the last with tlast. window_size of 0 or 1
// passes samples straight through. Write window_size only while the block
// is idle.
module sliding_median_filter_core
  import smf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [WSIZE_W-1:0]  cfg_wr_data,     // window_size
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,    // [15:0] sample
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata,    // [15:0] median_value
  output logic                m_axis_tlast
);

  logic [WSIZE_W-1:0] window_size;
  logic [CNT_W-1:0]   half;
  logic               out_take;
  logic               adv;
  stage_tag_t         tag;
  sample_t            history [MAX_WINDOW];
  sample_t            median;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WSIZE_W'(1);
    end else if (cfg_wr_en) begin
      window_size <= cfg_wr_data;
    end
  end

  assign out_take = !m_axis_tvalid || m_axis_tready;
  assign adv      = !tag.valid || out_take;

  smf_window u_window (
    .clk         (clk),
    .rst         (rst),
    .window_size (window_size),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_sample   (sample_t'(s_axis_tdata)),
    .in_last     (s_axis_tlast),
    .adv         (adv),
    .tag         (tag),
    .history     (history),
    .half        (half)
  );

  smf_rank_select u_select (
    .history (history),
    .half    (half),
    .median  (median)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (tag.valid && out_take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tag.valid && out_take) begin
      m_axis_tdata <= tag.bypass ? tag.data : median;
      m_axis_tlast <= tag.last;
    end
  end

  a_tag_not_lost: assert property (@(posedge clk) disable iff (rst)
    (tag.valid && !out_take) |=> tag.valid)
    else $error("pending request dropped under stall");

  a_out_loaded: assert property (@(posedge clk) disable iff (rst)
    (tag.valid && out_take) |=> m_axis_tvalid)
    else $error("request not moved to output");

  a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !adv |-> !s_axis_tready)
    else $error("input accepted with a blocked pipeline");

endmodule
